// File: sv/aepg_pkg.sv
// Shared types and constants for the antialiased edge pixel generator.
// Used by aepg_ctrl, aepg_datapath and the top level; no dependencies.
package aepg_pkg;

   localparam int MaxMesh  = 16;
   localparam int DivSteps = 25;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [23:0] pixel_value;
      logic               edge_pixel;
   } rsp_type;

   typedef struct packed {
      logic signed [17:0] grad_x;
      logic signed [17:0] grad_y;
      logic signed [19:0] center_x;
      logic signed [19:0] center_y;
      logic signed [15:0] level_a;
      logic signed [15:0] level_b;
      logic               mode_analytic;
      logic [4:0]         mesh_size;
   } cfg_type;

   localparam logic [2:0] RegGradX   = 3'd0;
   localparam logic [2:0] RegGradY   = 3'd1;
   localparam logic [2:0] RegCenterX = 3'd2;
   localparam logic [2:0] RegCenterY = 3'd3;
   localparam logic [2:0] RegLevelA  = 3'd4;
   localparam logic [2:0] RegLevelB  = 3'd5;
   localparam logic [2:0] RegMode    = 3'd6;
   localparam logic [2:0] RegMesh    = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_CORNER, ST_DECIDE, ST_AREA, ST_MESH_INIT,
      ST_MESH, ST_SQUARE, ST_DIV_SETUP, ST_DIV, ST_BLEND, ST_FINAL
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MUL, OP_SUM, OP_CORNER, OP_AREA, OP_MESH_INIT,
      OP_MESH, OP_SQUARE, OP_DIV_SETUP, OP_DIV, OP_BLEND, OP_FINAL
   } op_type;

   typedef enum logic [2:0] {
      AREA_NONE, AREA_TOP, AREA_MID, AREA_BOT, AREA_FULL
   } area_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic zero_grad;
      logic edge_hit;
      logic corner_last;
      logic mesh_last;
      logic div_last;
      logic out_free;
      logic analytic;
   } status_type;

endpackage

// File: sv/antialiased_edge_pixel_generator_top.sv
// Top level: register file, controller and datapath of the edge pixel generator.
// Depends on aepg_pkg, aepg_ctrl and aepg_datapath.
//
//   port group   dir    handshake              payload
//   req_*        in     req_valid / req_stall  req_data  (pixel_x, pixel_y)
//   rsp_*        out    rsp_valid / rsp_stall  rsp_data  (pixel_value, edge_pixel)
//   p*           in     psel / penable         paddr, pwdata, prdata
//
// Edge pixels pass through the 25-step restoring divider; mesh edge pixels first walk
// the mesh one sample a cycle. Synchronous reset clears control state and the tie
// parity and loads the configuration register defaults.
// A result waiting on rsp_stall is held in the output register; the next request
// is taken meanwhile and only its final write waits for the slot.
module antialiased_edge_pixel_generator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aepg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aepg_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   aepg_pkg::cfg_type    cfg_ff, cfg_in;
   aepg_pkg::cmd_type    cmd;
   aepg_pkg::status_type status;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            aepg_pkg::RegGradX:   cfg_in.grad_x        = pwdata[17:0];
            aepg_pkg::RegGradY:   cfg_in.grad_y        = pwdata[17:0];
            aepg_pkg::RegCenterX: cfg_in.center_x      = pwdata[19:0];
            aepg_pkg::RegCenterY: cfg_in.center_y      = pwdata[19:0];
            aepg_pkg::RegLevelA:  cfg_in.level_a       = pwdata[15:0];
            aepg_pkg::RegLevelB:  cfg_in.level_b       = pwdata[15:0];
            aepg_pkg::RegMode:    cfg_in.mode_analytic = pwdata[0];
            aepg_pkg::RegMesh:    cfg_in.mesh_size     = pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grad_x        <= 18'sd0;
         cfg_ff.grad_y        <= 18'sd65536;
         cfg_ff.center_x      <= 20'sd12800;
         cfg_ff.center_y      <= 20'sd12800;
         cfg_ff.level_a       <= 16'sd255;
         cfg_ff.level_b       <= 16'sd0;
         cfg_ff.mode_analytic <= 1'b1;
         cfg_ff.mesh_size     <= 5'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         aepg_pkg::RegGradX:   prdata = 32'(cfg_ff.grad_x);
         aepg_pkg::RegGradY:   prdata = 32'(cfg_ff.grad_y);
         aepg_pkg::RegCenterX: prdata = 32'(cfg_ff.center_x);
         aepg_pkg::RegCenterY: prdata = 32'(cfg_ff.center_y);
         aepg_pkg::RegLevelA:  prdata = 32'(cfg_ff.level_a);
         aepg_pkg::RegLevelB:  prdata = 32'(cfg_ff.level_b);
         aepg_pkg::RegMode:    prdata = 32'(cfg_ff.mode_analytic);
         aepg_pkg::RegMesh:    prdata = 32'(cfg_ff.mesh_size);
         default:              prdata = 32'd0;
      endcase
   end

   aepg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aepg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a taken request keeps the input closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // the final write always lands a result on the output
   a_final_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == aepg_pkg::OP_FINAL) |=> rsp_valid)
      else $error("final write lost");

   // the final write only happens into a free output slot
   a_final_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == aepg_pkg::OP_FINAL) |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

endmodule

// File: sv/aepg_ctrl.sv
// Controller FSM: sequences corner tests, mesh sampling, divider and output.
// Depends on aepg_pkg.
module aepg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aepg_pkg::status_type status,
   output aepg_pkg::cmd_type    cmd
);

   aepg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aepg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = aepg_pkg::OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         aepg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = aepg_pkg::OP_LOAD;
               state_in = aepg_pkg::ST_MUL;
            end
         end
         aepg_pkg::ST_MUL: begin
            cmd.op   = aepg_pkg::OP_MUL;
            state_in = aepg_pkg::ST_SUM;
         end
         aepg_pkg::ST_SUM: begin
            cmd.op   = aepg_pkg::OP_SUM;
            state_in = status.zero_grad ? aepg_pkg::ST_FINAL : aepg_pkg::ST_CORNER;
         end
         aepg_pkg::ST_CORNER: begin
            cmd.op = aepg_pkg::OP_CORNER;
            if (status.corner_last) state_in = aepg_pkg::ST_DECIDE;
         end
         aepg_pkg::ST_DECIDE: begin
            if (!status.edge_hit) state_in = aepg_pkg::ST_FINAL;
            else if (status.analytic) state_in = aepg_pkg::ST_AREA;
            else state_in = aepg_pkg::ST_MESH_INIT;
         end
         aepg_pkg::ST_AREA: begin
            cmd.op   = aepg_pkg::OP_AREA;
            state_in = aepg_pkg::ST_SQUARE;
         end
         aepg_pkg::ST_MESH_INIT: begin
            cmd.op   = aepg_pkg::OP_MESH_INIT;
            state_in = aepg_pkg::ST_MESH;
         end
         aepg_pkg::ST_MESH: begin
            cmd.op = aepg_pkg::OP_MESH;
            if (status.mesh_last) state_in = aepg_pkg::ST_SQUARE;
         end
         aepg_pkg::ST_SQUARE: begin
            cmd.op   = aepg_pkg::OP_SQUARE;
            state_in = aepg_pkg::ST_DIV_SETUP;
         end
         aepg_pkg::ST_DIV_SETUP: begin
            cmd.op   = aepg_pkg::OP_DIV_SETUP;
            state_in = aepg_pkg::ST_DIV;
         end
         aepg_pkg::ST_DIV: begin
            cmd.op = aepg_pkg::OP_DIV;
            if (status.div_last) state_in = aepg_pkg::ST_BLEND;
         end
         aepg_pkg::ST_BLEND: begin
            cmd.op   = aepg_pkg::OP_BLEND;
            state_in = aepg_pkg::ST_FINAL;
         end
         aepg_pkg::ST_FINAL: begin
            if (status.out_free) begin
               cmd.op   = aepg_pkg::OP_FINAL;
               state_in = aepg_pkg::ST_IDLE;
            end
         end
         default: state_in = aepg_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: sv/aepg_datapath.sv
// Datapath: edge evaluation, tie parity, area / mesh coverage, restoring divider,
// blend and output register. Depends on aepg_pkg.
module aepg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  aepg_pkg::cfg_type    cfg,
   input  aepg_pkg::req_type    req_data,
   input  aepg_pkg::cmd_type    cmd,
   output aepg_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aepg_pkg::rsp_type    rsp_data
);

   aepg_pkg::req_type  in_ff, in_in;
   logic signed [39:0] prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [47:0] e00_ff, e00_in, e_ff, e_in, row_ff, row_in;
   logic [1:0]         corner_ff, corner_in;
   logic [2:0]         cnt4_ff, cnt4_in;
   logic               parity_ff, parity_in;
   logic [3:0]         col_ff, col_in, line_ff, line_in;
   logic [8:0]         ss_ff, ss_in;
   aepg_pkg::area_type kind_ff, kind_in;
   logic [25:0]        opnd_ff, opnd_in;
   logic [51:0]        sq_ff, sq_in;
   logic [35:0]        gh_ff, gh_in;
   logic [63:0]        rem_ff, rem_in, dsh_ff, dsh_in;
   logic [24:0]        quo_ff, quo_in;
   logic [4:0]         step_ff, step_in;
   logic               neg_ff, neg_in;
   logic signed [34:0] blend_ff, blend_in;
   aepg_pkg::rsp_type  out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic signed [20:0] x0, y0;
   logic signed [21:0] dx, dy;
   logic signed [47:0] gx_w, gy_w, dval, gg, hh, e_next;
   logic [17:0]        ax, ay, g_mag, h_mag;
   logic [4:0]         msz;
   logic [3:0]         k;
   logic signed [16:0] diff;
   logic [16:0]        absd, a16;
   logic               hit, tie;
   logic signed [27:0] vsum, term;

   assign gx_w  = 48'(cfg.grad_x);
   assign gy_w  = 48'(cfg.grad_y);
   assign x0    = $signed({3'b000, in_ff.pixel_x, 8'h00}) - 21'sd128;
   assign y0    = $signed({3'b000, in_ff.pixel_y, 8'h00}) - 21'sd128;
   assign dx    = 22'(x0) - 22'(cfg.center_x);
   assign dy    = 22'(y0) - 22'(cfg.center_y);
   assign ax    = cfg.grad_x[17] ? 18'(-cfg.grad_x) : 18'(cfg.grad_x);
   assign ay    = cfg.grad_y[17] ? 18'(-cfg.grad_y) : 18'(cfg.grad_y);
   assign h_mag = (ax < ay) ? ay : ax;
   assign g_mag = (ax < ay) ? ax : ay;
   assign gg    = $signed({23'd0, g_mag, 7'd0});
   assign hh    = $signed({23'd0, h_mag, 7'd0});
   // line offset relative to the pixel centre, negated edge value
   assign dval  = -(e00_ff + (gx_w <<< 7) + (gy_w <<< 7));
   assign msz   = (cfg.mesh_size < 5'd2) ? 5'd2 :
                  (cfg.mesh_size > 5'(aepg_pkg::MaxMesh)) ? 5'(aepg_pkg::MaxMesh) :
                  cfg.mesh_size;
   assign k     = 4'(msz - 5'd1);
   assign diff  = 17'(cfg.level_a) - 17'(cfg.level_b);
   assign absd  = diff[16] ? 17'(-diff) : 17'(diff);

   // point test; a tie flips the parity and takes its new value
   assign tie   = (e_ff == 48'sd0);
   assign hit   = tie ? ~parity_ff : ~e_ff[47];

   always_comb begin
      unique case (kind_ff)
         aepg_pkg::AREA_TOP:  a16 = quo_ff[16:0];
         aepg_pkg::AREA_MID:  a16 = quo_ff[16:0];
         aepg_pkg::AREA_BOT:  a16 = 17'd65536 - quo_ff[16:0];
         aepg_pkg::AREA_FULL: a16 = 17'd65536;
         default:             a16 = 17'd0;
      endcase
   end

   always_comb begin
      if (cfg.grad_x == 18'sd0 && cfg.grad_y == 18'sd0) begin
         term = 28'(cfg.level_a) <<< 8;
      end else if (cnt4_ff == 3'd0) begin
         term = 28'(cfg.level_b) <<< 8;
      end else if (cnt4_ff == 3'd4) begin
         term = 28'(cfg.level_a) <<< 8;
      end else if (cfg.mode_analytic) begin
         term = (28'(cfg.level_b) <<< 8) + 28'((blend_ff + 35'sd128) >>> 8);
      end else begin
         term = (28'(cfg.level_b) <<< 8)
              + (neg_ff ? -$signed({3'd0, quo_ff}) : $signed({3'd0, quo_ff}));
      end
      vsum = term;
   end

   always_comb begin
      in_in        = in_ff;
      prodx_in     = prodx_ff;
      prody_in     = prody_ff;
      e00_in       = e00_ff;
      e_in         = e_ff;
      row_in       = row_ff;
      corner_in    = corner_ff;
      cnt4_in      = cnt4_ff;
      parity_in    = parity_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      ss_in        = ss_ff;
      kind_in      = kind_ff;
      opnd_in      = opnd_ff;
      sq_in        = sq_ff;
      gh_in        = gh_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      blend_in     = blend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      e_next       = e_ff;
      unique case (cmd.op)
         aepg_pkg::OP_LOAD: begin
            in_in   = req_data;
            cnt4_in = 3'd0;
         end
         aepg_pkg::OP_MUL: begin
            prodx_in = 40'(cfg.grad_x) * 40'(dx);
            prody_in = 40'(cfg.grad_y) * 40'(dy);
         end
         aepg_pkg::OP_SUM: begin
            e00_in    = 48'(prodx_ff) + 48'(prody_ff);
            e_in      = 48'(prodx_ff) + 48'(prody_ff);
            corner_in = 2'd0;
         end
         aepg_pkg::OP_CORNER: begin
            if (tie) parity_in = ~parity_ff;
            cnt4_in   = cnt4_ff + 3'(hit);
            corner_in = corner_ff + 2'd1;
            // walk (-,-) (+,-) (+,+) (-,+)
            case (corner_ff)
               2'd0:    e_in = e_ff + (gx_w <<< 8);
               2'd1:    e_in = e_ff + (gy_w <<< 8);
               default: e_in = e_ff - (gx_w <<< 8);
            endcase
         end
         aepg_pkg::OP_AREA: begin
            if (dval - gg > hh) begin
               kind_in = aepg_pkg::AREA_NONE;
               opnd_in = 26'd0;
            end else if (dval + gg > hh) begin
               kind_in = aepg_pkg::AREA_TOP;
               opnd_in = 26'(gg + hh - dval);
            end else if (dval - gg > -hh) begin
               kind_in = aepg_pkg::AREA_MID;
               opnd_in = 26'(hh - dval);
            end else if (dval + gg > -hh) begin
               kind_in = aepg_pkg::AREA_BOT;
               opnd_in = 26'(dval + gg + hh);
            end else begin
               kind_in = aepg_pkg::AREA_FULL;
               opnd_in = 26'd0;
            end
         end
         aepg_pkg::OP_MESH_INIT: begin
            e_next  = e00_ff * 48'($signed({1'b0, k}));
            e_in    = e_next;
            row_in  = e_next;
            col_in  = 4'd0;
            line_in = 4'd0;
            ss_in   = 9'd0;
         end
         aepg_pkg::OP_MESH: begin
            if (tie) parity_in = ~parity_ff;
            ss_in = ss_ff + 9'(hit);
            if (col_ff == k) begin
               col_in  = 4'd0;
               line_in = line_ff + 4'd1;
               row_in  = row_ff + (gy_w <<< 8);
               e_in    = row_ff + (gy_w <<< 8);
            end else begin
               col_in = col_ff + 4'd1;
               e_in   = e_ff + (gx_w <<< 8);
            end
         end
         aepg_pkg::OP_SQUARE: begin
            neg_in = diff[16];
            if (cfg.mode_analytic) begin
               sq_in = 52'(opnd_ff) * 52'(opnd_ff);
               gh_in = 36'(g_mag) * 36'(h_mag);
            end else begin
               sq_in = 52'(absd) * 52'(ss_ff);
               gh_in = 36'(msz) * 36'(msz);
            end
         end
         aepg_pkg::OP_DIV_SETUP: begin
            quo_in  = 25'd0;
            step_in = 5'd0;
            if (cfg.mode_analytic && kind_ff == aepg_pkg::AREA_MID) begin
               rem_in = (64'(opnd_ff) << 8) + 64'(h_mag >> 1);
               dsh_in = 64'(h_mag) << (aepg_pkg::DivSteps - 1);
            end else if (cfg.mode_analytic) begin
               rem_in = 64'(sq_ff) + 64'(gh_ff);
               dsh_in = 64'(gh_ff) << aepg_pkg::DivSteps;
            end else begin
               rem_in = (64'(sq_ff) << 9) + 64'(gh_ff) - 64'(neg_ff);
               dsh_in = 64'(gh_ff) << aepg_pkg::DivSteps;
            end
         end
         aepg_pkg::OP_DIV: begin
            step_in = step_ff + 5'd1;
            dsh_in  = dsh_ff >> 1;
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[23:0], 1'b1};
            end else begin
               quo_in = {quo_ff[23:0], 1'b0};
            end
         end
         aepg_pkg::OP_BLEND: begin
            blend_in = 35'(diff) * 35'($signed({1'b0, a16}));
         end
         aepg_pkg::OP_FINAL: begin
            out_valid_in = 1'b1;
            if (vsum > 28'sd8388607) out_in.pixel_value = 24'sd8388607;
            else if (vsum < -28'sd8388608) out_in.pixel_value = -24'sd8388608;
            else out_in.pixel_value = 24'(vsum);
            out_in.edge_pixel = !(cfg.grad_x == 18'sd0 && cfg.grad_y == 18'sd0)
                                && cnt4_ff != 3'd0 && cnt4_ff != 3'd4;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         parity_ff    <= parity_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff     <= in_in;
      prodx_ff  <= prodx_in;
      prody_ff  <= prody_in;
      e00_ff    <= e00_in;
      e_ff      <= e_in;
      row_ff    <= row_in;
      corner_ff <= corner_in;
      cnt4_ff   <= cnt4_in;
      col_ff    <= col_in;
      line_ff   <= line_in;
      ss_ff     <= ss_in;
      kind_ff   <= kind_in;
      opnd_ff   <= opnd_in;
      sq_ff     <= sq_in;
      gh_ff     <= gh_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      blend_ff  <= blend_in;
      out_ff    <= out_in;
   end

   // the mid-band case divides by H alone, so its divisor starts one place lower
   assign status.zero_grad   = (cfg.grad_x == 18'sd0 && cfg.grad_y == 18'sd0);
   assign status.edge_hit    = (cnt4_ff != 3'd0 && cnt4_ff != 3'd4);
   assign status.corner_last = (corner_ff == 2'd3);
   assign status.mesh_last   = (col_ff == k && line_ff == k);
   assign status.div_last    = (step_ff == 5'(aepg_pkg::DivSteps - 1));
   assign status.out_free    = !out_valid_ff || !rsp_stall;
   assign status.analytic    = cfg.mode_analytic;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: dv/tb_top.sv
// Testbench for the antialiased edge pixel generator: directed table, then random requests,
// checked against a behavioural predictor. Depends on aepg_pkg and the top level.
`timescale 1ns / 100ps

module tb_top;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   aepg_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   aepg_pkg::rsp_type rsp_data;
   logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   antialiased_edge_pixel_generator_top u_dut (.*);

   always #2 clock = ~clock;

   // predictor state
   longint gx, gy, cx, cy, la, lb;
   bit      analytic;
   int      mesh;
   bit      parity;

   aepg_pkg::rsp_type pixel_q[$];
   int      n_fail = 0;
   int      n_row_fail = 0;
   bit      calm = 1'b0;
   bit      hold_long = 1'b0;
   int      stall_left = 0;
   longint  cycles = 0;

   function automatic longint sx(longint v, int w);
      longint m;
      m = (64'sd1 <<< w) - 1;
      v = v & m;
      if (v[w-1]) v = v - (64'sd1 <<< w);
      return v;
   endfunction

   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic int corner_side(longint e);
      if (e > 0) return 1;
      if (e < 0) return 0;
      parity = ~parity;
      return parity;
   endfunction

   function automatic longint coverage16(longint d, longint g, longint h);
      longint hh, gg, gh2, p;
      hh = 128 * h; gg = 128 * g; gh2 = 2 * g * h;
      if (d - gg > hh) return 0;
      if (d + gg > hh) begin
         p = gg + hh - d;
         return (p * p + gh2 / 2) / gh2;
      end
      if (d - gg > -hh) return (256 * (hh - d) + h / 2) / h;
      if (d + gg > -hh) begin
         p = d + gg + hh;
         return 65536 - (p * p + gh2 / 2) / gh2;
      end
      return 65536;
   endfunction

   function automatic aepg_pkg::rsp_type shade_pixel(aepg_pkg::req_type rq);
      aepg_pkg::rsp_type r;
      longint x, y, x0, x1, y0, y1, v, diff, ax, ay, g, h, d, m, k, ss, xs, ys;
      int s;
      r = '0;
      x = rq.pixel_x; y = rq.pixel_y;
      if (gx == 0 && gy == 0) v = 256 * la;
      else begin
         x0 = 256 * x - 128; x1 = 256 * x + 128;
         y0 = 256 * y - 128; y1 = 256 * y + 128;
         s = corner_side(gx * (x0 - cx) + gy * (y0 - cy));
         s += corner_side(gx * (x1 - cx) + gy * (y0 - cy));
         s += corner_side(gx * (x1 - cx) + gy * (y1 - cy));
         s += corner_side(gx * (x0 - cx) + gy * (y1 - cy));
         diff = la - lb;
         if (s == 0) v = 256 * lb;
         else if (s == 4) v = 256 * la;
         else begin
            r.edge_pixel = 1'b1;
            if (analytic) begin
               ax = gx < 0 ? -gx : gx;
               ay = gy < 0 ? -gy : gy;
               if (ax < ay) begin h = ay; g = ax; end
               else begin h = ax; g = ay; end
               d = gy * (cy - 256 * y) + gx * (cx - 256 * x);
               v = 256 * lb + fdiv(diff * coverage16(d, g, h) + 128, 256);
            end else begin
               m = mesh < 2 ? 2 : (mesh > aepg_pkg::MaxMesh ? aepg_pkg::MaxMesh : mesh);
               k = m - 1; ss = 0;
               for (longint j = 0; j < m; j++) begin
                  ys = y0 * k + 256 * j;
                  for (longint i = 0; i < m; i++) begin
                     xs = x0 * k + 256 * i;
                     ss += corner_side(gx * (xs - cx * k) + gy * (ys - cy * k));
                  end
               end
               v = 256 * lb + fdiv(2 * diff * 256 * ss + m * m, 2 * m * m);
            end
         end
      end
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      r.pixel_value = v[23:0];
      return r;
   endfunction

   task automatic csr_write(logic [2:0] idx, longint val);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= val[31:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         aepg_pkg::RegGradX:   gx = sx(val, 18);
         aepg_pkg::RegGradY:   gy = sx(val, 18);
         aepg_pkg::RegCenterX: cx = sx(val, 20);
         aepg_pkg::RegCenterY: cy = sx(val, 20);
         aepg_pkg::RegLevelA:  la = sx(val, 16);
         aepg_pkg::RegLevelB:  lb = sx(val, 16);
         aepg_pkg::RegMode:    analytic = val[0];
         default:              mesh = int'(val & 31);
      endcase
   endtask

   // closes the input and waits until every request has come back
   task automatic drain;
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic send_pixel(aepg_pkg::req_type rq, bit check_val, aepg_pkg::rsp_type want);
      aepg_pkg::rsp_type p;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = shade_pixel(rq);
      if (check_val && p !== want) begin
         $display("%0t directed row expected %h, predicted %h", $time, want, p);
         n_row_fail++;
      end
      pixel_q.push_back(p);
   endtask

   function automatic aepg_pkg::req_type rnd_pixel();
      aepg_pkg::req_type r;
      r.pixel_x = 10'($urandom_range(0, 1023));
      r.pixel_y = 10'($urandom_range(0, 1023));
      return r;
   endfunction

   // near-edge pixel for the current centre
   function automatic aepg_pkg::req_type near_pixel();
      aepg_pkg::req_type r;
      longint px, py;
      px = (cx >>> 8) + $urandom_range(0, 8) - 4;
      py = (cy >>> 8) + $urandom_range(0, 8) - 4;
      r.pixel_x = px[9:0];
      r.pixel_y = py[9:0];
      return r;
   endfunction

   typedef struct {
      logic [9:0]        x, y;
      bit                known;
      aepg_pkg::rsp_type want;
   } row_type;

   // receiver side with random stall bursts and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (hold_long) begin
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(1, 9)) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      aepg_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            n_fail++;
         end else begin
            e = pixel_q.pop_front();
            if (rsp_data.pixel_value !== e.pixel_value) begin
               $display("%0t pixel_value expected %h actual %h", $time,
                        e.pixel_value, rsp_data.pixel_value);
               n_fail++;
            end
            if (rsp_data.edge_pixel !== e.edge_pixel) begin
               $display("%0t edge_pixel expected %b actual %b", $time,
                        e.edge_pixel, rsp_data.edge_pixel);
               n_fail++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("antialiased_edge_pixel_generator_top: mismatch");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      aepg_pkg::req_type rq;
      gx = 0; gy = 65536; cx = 12800; cy = 12800; la = 255; lb = 0;
      analytic = 1; mesh = 4; parity = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset config: horizontal edge at y = 50; pixels on row 50 straddle it
      rows.push_back('{10'd0, 10'd0, 1, '{24'sd0, 1'b0}});
      rows.push_back('{10'd1023, 10'd1023, 1, '{24'sd65280, 1'b0}});
      rows.push_back('{10'd1023, 10'd0, 1, '{24'sd0, 1'b0}});
      rows.push_back('{10'd0, 10'd1023, 1, '{24'sd65280, 1'b0}});
      rows.push_back('{10'd50, 10'd50, 0, '{24'sd0, 1'b0}});
      rows.push_back('{10'd7, 10'd50, 0, '{24'sd0, 1'b0}});
      rows.push_back('{10'd50, 10'd49, 0, '{24'sd0, 1'b0}});
      rows.push_back('{10'd50, 10'd51, 0, '{24'sd0, 1'b0}});
      foreach (rows[i]) begin
         rq.pixel_x = rows[i].x; rq.pixel_y = rows[i].y;
         send_pixel(rq, rows[i].known, rows[i].want);
      end
      drain();

      // zero gradient: everything is level_a, extreme levels saturate nowhere
      csr_write(aepg_pkg::RegGradY, 0);
      csr_write(aepg_pkg::RegLevelA, 32767);
      csr_write(aepg_pkg::RegLevelB, -32768);
      rq = '0; send_pixel(rq, 1, '{24'sd8388352, 1'b0});
      rq = '1; send_pixel(rq, 1, '{24'sd8388352, 1'b0});
      drain();

      // diagonal edge, mesh mode at extremes of mesh size
      csr_write(aepg_pkg::RegGradX, 65536);
      csr_write(aepg_pkg::RegGradY, -65536);
      csr_write(aepg_pkg::RegCenterX, 524287);
      csr_write(aepg_pkg::RegCenterY, -524288);
      csr_write(aepg_pkg::RegMode, 0);
      csr_write(aepg_pkg::RegMesh, 0);
      rq = '{10'd20, 10'd20}; send_pixel(rq, 0, '0);
      drain();
      csr_write(aepg_pkg::RegMesh, 31);
      rq = '{10'd0, 10'd1023}; send_pixel(rq, 0, '0);
      drain();
      csr_write(aepg_pkg::RegCenterX, 25600);
      csr_write(aepg_pkg::RegCenterY, 25600);
      for (int i = 95; i < 105; i++) begin
         rq = '{i[9:0], 10'd100}; send_pixel(rq, 0, '0);
      end
      drain();

      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         csr_write(aepg_pkg::RegGradX, $urandom_range(0, 131072) - 65536);
         csr_write(aepg_pkg::RegGradY,
                   (ph % 5 == 0) ? 0 : $urandom_range(0, 131072) - 65536);
         csr_write(aepg_pkg::RegCenterX, $urandom_range(0, 262143));
         csr_write(aepg_pkg::RegCenterY, (ph == 3) ? 524287 : $urandom_range(0, 262143));
         csr_write(aepg_pkg::RegLevelA, $urandom_range(0, 65535));
         csr_write(aepg_pkg::RegLevelB, $urandom_range(0, 65535));
         csr_write(aepg_pkg::RegMode, ph % 2);
         csr_write(aepg_pkg::RegMesh, (ph % 4 == 1) ? 16 : $urandom_range(2, 5));
         if (ph == 11) calm = 1;
         if (ph == 2) fork
            begin hold_long = 1; repeat (600) @(posedge clock); hold_long = 0; end
         join_none
         for (int n = 0; n < 170; n++) begin
            rq = ($urandom_range(0, 2) != 0) ? near_pixel() : rnd_pixel();
            send_pixel(rq, 0, '0);
         end
         drain();
      end

      if (n_fail == 0 && n_row_fail == 0)
         $display("antialiased_edge_pixel_generator_top: match");
      else
         $display("antialiased_edge_pixel_generator_top: mismatch");
      $finish;
   end
endmodule
